/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check that is switched off while reset is held
`define PSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define PSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/psp_pkg.sv */
// ---------------------------------------------------------------------------
// psp_pkg
// Types, constants and header byte tables of the program stream packetizer.
// ---------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

    localparam int BYTE_W         = 8;
    localparam int TS_W           = 42;
    localparam int TIME_W         = 33;
    localparam int FRAME_LEN_BITS = 24;
    localparam int CHUNK_W        = 16;
    localparam int CMP_W          = (FRAME_LEN_BITS > CHUNK_W) ? FRAME_LEN_BITS : CHUNK_W;
    localparam int IDX_W          = 6;
    localparam int EXT_W          = 9;

    // header group and PES header sizes in bytes
    localparam int PACK_LEN    = 14;
    localparam int SYS_LEN     = 18;
    localparam int MAP_LEN     = 24;
    localparam int PES_HDR_LEN = 19;

    localparam logic [IDX_W-1:0] IDX_PACK_TIME        = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_PACK_MUX         = IDX_W'(10);
    localparam logic [IDX_W-1:0] IDX_SYS              = IDX_W'(PACK_LEN);
    localparam logic [IDX_W-1:0] IDX_FRAME_LAST_KEY   = IDX_W'(PACK_LEN + SYS_LEN + MAP_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_FRAME_LAST_NOKEY = IDX_W'(PACK_LEN + MAP_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_PES_LEN          = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_PES_PTS          = IDX_W'(9);
    localparam logic [IDX_W-1:0] IDX_PES_DTS          = IDX_W'(14);
    localparam logic [IDX_W-1:0] IDX_PES_DATA         = IDX_W'(PES_HDR_LEN);

    localparam logic [CHUNK_W-1:0] LIMIT_RESET   = CHUNK_W'(1300);
    localparam logic [CHUNK_W-1:0] LIMIT_MAX     = CHUNK_W'(65522);
    localparam logic [CHUNK_W-1:0] PES_LEN_EXTRA = CHUNK_W'(13);

    // digit-serial divide of the timestamp by 100 and by 300
    localparam int SCR_DIV   = 100;
    localparam int DTS_DIV   = 300;
    localparam int REM100_W  = $clog2(SCR_DIV);
    localparam int REM300_W  = $clog2(DTS_DIV);
    localparam int DIV_BITS  = 6;
    localparam int DIV_STEPS = (TS_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    typedef enum logic {
        KIND_FRAME,
        KIND_PES
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic                key;
        logic                eoc;
        logic                eof;
        logic [CHUNK_W-1:0]  pes_len;
        logic [BYTE_W-1:0]   data;
    } t_job;

    // fixed bytes of pack header, system header and stream map (key layout)
    function automatic logic [BYTE_W-1:0] frame_const_byte(input logic [IDX_W-1:0] e);
        logic [BYTE_W-1:0] b;
        unique case (e)
            6'd2:    b = 8'h01;
            6'd3:    b = 8'hBA;
            6'd11:   b = 8'h03;
            6'd12:   b = 8'hFF;
            6'd13:   b = 8'hF8;
            6'd16:   b = 8'h01;
            6'd17:   b = 8'hBB;
            6'd19:   b = 8'h0C;
            6'd20:   b = 8'h81;
            6'd21:   b = 8'h86;
            6'd22:   b = 8'hA1;
            6'd23:   b = 8'h05;
            6'd24:   b = 8'hE1;
            6'd25:   b = 8'h7F;
            6'd26:   b = 8'hC0;
            6'd27:   b = 8'hC2;
            6'd29:   b = 8'hE0;
            6'd30:   b = 8'hE8;
            6'd34:   b = 8'h01;
            6'd35:   b = 8'hBC;
            6'd37:   b = 8'h12;
            6'd38:   b = 8'hE0;
            6'd39:   b = 8'hFF;
            6'd43:   b = 8'h08;
            6'd44:   b = 8'h90;
            6'd45:   b = 8'hC0;
            6'd48:   b = 8'h1B;
            6'd49:   b = 8'hE0;
            6'd52:   b = 8'h45;
            6'd53:   b = 8'hBD;
            6'd54:   b = 8'hDC;
            6'd55:   b = 8'hF4;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // fixed bytes of the PES header
    function automatic logic [BYTE_W-1:0] pes_const_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            6'd2:    b = 8'h01;
            6'd3:    b = 8'hE0;
            6'd6:    b = 8'h80;
            6'd7:    b = 8'hC0;
            6'd8:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/psp_div.sv */
// ---------------------------------------------------------------------------
// psp_div
// Digit-serial divide of the timestamp by 100 and by 300, six bits a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module psp_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [psp_pkg::TS_W-1:0]      i_ts,
    output logic                               o_busy,
    output logic [psp_pkg::TIME_W-1:0]         o_q100,
    output logic [psp_pkg::REM100_W-1:0]       o_r100,
    output logic [psp_pkg::TIME_W-1:0]         o_q300
);
    import psp_pkg::*;

    logic                  r_busy;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]      r_sh;
    logic [TIME_W-1:0]     r_q100;
    logic [TIME_W-1:0]     r_q300;
    logic [REM100_W-1:0]   r_r100;
    logic [REM300_W-1:0]   r_r300;

    logic [TIME_W-1:0]     n_q100;
    logic [TIME_W-1:0]     n_q300;
    logic [REM100_W-1:0]   n_r100;
    logic [REM300_W-1:0]   n_r300;

    always_comb begin
        logic [REM100_W:0] t100;
        logic [REM300_W:0] t300;
        n_q100 = r_q100;
        n_q300 = r_q300;
        n_r100 = r_r100;
        n_r300 = r_r300;
        for (int k = 0; k < DIV_BITS; k++) begin
            t100 = {n_r100, r_sh[DIV_W-1-k]};
            t300 = {n_r300, r_sh[DIV_W-1-k]};
            if (t100 >= (REM100_W+1)'(SCR_DIV)) begin
                n_r100 = REM100_W'(t100 - (REM100_W+1)'(SCR_DIV));
                n_q100 = {n_q100[TIME_W-2:0], 1'b1};
            end else begin
                n_r100 = t100[REM100_W-1:0];
                n_q100 = {n_q100[TIME_W-2:0], 1'b0};
            end
            if (t300 >= (REM300_W+1)'(DTS_DIV)) begin
                n_r300 = REM300_W'(t300 - (REM300_W+1)'(DTS_DIV));
                n_q300 = {n_q300[TIME_W-2:0], 1'b1};
            end else begin
                n_r300 = t300[REM300_W-1:0];
                n_q300 = {n_q300[TIME_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh   <= DIV_W'(i_ts);
            r_q100 <= '0;
            r_q300 <= '0;
            r_r100 <= '0;
            r_r300 <= '0;
        end else if (r_busy) begin
            r_sh   <= r_sh << DIV_BITS;
            r_q100 <= n_q100;
            r_q300 <= n_q300;
            r_r100 <= n_r100;
            r_r300 <= n_r300;
        end
    end

    assign o_busy = r_busy;
    assign o_q100 = r_q100;
    assign o_r100 = r_r100;
    assign o_q300 = r_q300;

endmodule

`default_nettype wire

/* rtl/core/psp_byte_sel.sv */
// ---------------------------------------------------------------------------
// psp_byte_sel
// Picks the output byte of the current job at a given byte position.
// ---------------------------------------------------------------------------
`default_nettype none

module psp_byte_sel (
    input  wire psp_pkg::t_job                  i_job,
    input  wire logic [psp_pkg::IDX_W-1:0]      i_idx,
    input  wire logic [psp_pkg::TIME_W-1:0]     i_pts,
    input  wire logic [psp_pkg::REM100_W-1:0]   i_ext,
    input  wire logic [psp_pkg::TIME_W-1:0]     i_dts,
    output logic [psp_pkg::BYTE_W-1:0]          o_byte
);
    import psp_pkg::*;

    logic [IDX_W-1:0] frame_e;
    logic [47:0]      pack_time;
    logic [39:0]      pts_vec;
    logic [39:0]      dts_vec;
    logic [EXT_W-1:0] ext_w;
    logic [2:0]       k_pack;
    logic [2:0]       k_pts;
    logic [2:0]       k_dts;
    logic [47:0]      pack_sh;
    logic [39:0]      pts_sh;
    logic [39:0]      dts_sh;

    assign ext_w = EXT_W'(i_ext);

    // scr base equals the presentation time
    assign pack_time = {2'b01, i_pts[32:30], 1'b1, i_pts[29:15], 1'b1, i_pts[14:0], 1'b1,
                        ext_w, 1'b1};
    assign pts_vec = {4'h3, i_pts[32:30], 1'b1, i_pts[29:15], 1'b1, i_pts[14:0], 1'b1};
    assign dts_vec = {4'h1, i_dts[32:30], 1'b1, i_dts[29:15], 1'b1, i_dts[14:0], 1'b1};

    // without a system header the map follows the pack header directly
    assign frame_e = (!i_job.key && (i_idx >= IDX_SYS)) ? i_idx + IDX_W'(SYS_LEN) : i_idx;

    assign k_pack  = 3'(frame_e - IDX_PACK_TIME);
    assign k_pts   = 3'(i_idx - IDX_PES_PTS);
    assign k_dts   = 3'(i_idx - IDX_PES_DTS);
    assign pack_sh = pack_time << {k_pack, 3'b000};
    assign pts_sh  = pts_vec << {k_pts, 3'b000};
    assign dts_sh  = dts_vec << {k_dts, 3'b000};

    always_comb begin
        if (i_job.kind == KIND_FRAME) begin
            priority if (frame_e < IDX_PACK_TIME || frame_e >= IDX_PACK_MUX) begin
                o_byte = frame_const_byte(frame_e);
            end else begin
                o_byte = pack_sh[47:40];
            end
        end else begin
            priority if (i_idx < IDX_PES_LEN) begin
                o_byte = pes_const_byte(i_idx);
            end else if (i_idx == IDX_PES_LEN) begin
                o_byte = i_job.pes_len[15:8];
            end else if (i_idx == IDX_PES_LEN + 1'b1) begin
                o_byte = i_job.pes_len[7:0];
            end else if (i_idx < IDX_PES_PTS) begin
                o_byte = pes_const_byte(i_idx);
            end else if (i_idx < IDX_PES_DTS) begin
                o_byte = pts_sh[39:32];
            end else if (i_idx < IDX_PES_DATA) begin
                o_byte = dts_sh[39:32];
            end else begin
                o_byte = i_job.data;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/program_stream_packetizer.sv */
// ---------------------------------------------------------------------------
// program_stream_packetizer
// Packs video frames into an MPEG-2 program stream, one byte per output word.
// ---------------------------------------------------------------------------
// payload word without PES header: 1 output word via the job and output registers, 1 word/cycle unless stalled
// payload word opening a PES packet: 20 output words, one per cycle unless the output stalls
// frame start: timestamp divide, then 38 or 56 header words, one per cycle unless the output stalls
// the job register takes the next word when it is empty or when its current job sends its last byte
// reset (synchronous, active low) empties both stages, clears the frame state
// and sets the payload limit to 1300
`default_nettype none

module program_stream_packetizer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_mode,
    input  wire logic [psp_pkg::TS_W-1:0]             i_timestamp_ms,
    input  wire logic                                 i_key_frame,
    input  wire logic [psp_pkg::FRAME_LEN_BITS-1:0]   i_frame_length,
    input  wire logic [psp_pkg::BYTE_W-1:0]           i_payload_byte,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [psp_pkg::BYTE_W-1:0]                o_out_byte,
    output logic                                      o_end_of_chunk,
    output logic                                      o_end_of_frame,
    output logic                                      o_last_of_item,
    input  wire logic                                 i_cfg_we,
    input  wire logic [psp_pkg::CHUNK_W-1:0]          i_cfg_data
);
    import psp_pkg::*;

    logic [CHUNK_W-1:0]         r_limit;
    logic [FRAME_LEN_BITS-1:0]  r_frame_rem;
    logic [CHUNK_W-1:0]         r_chunk_rem;
    logic                       r_job_valid;
    t_job                       r_job;
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_last_idx;
    logic                       r_out_valid;
    logic [BYTE_W-1:0]          r_out_byte;
    logic                       r_out_eoc;
    logic                       r_out_eof;
    logic                       r_out_last;

    logic [CHUNK_W-1:0]         n_limit;
    logic [FRAME_LEN_BITS-1:0]  n_frame_rem;
    logic [CHUNK_W-1:0]         n_chunk_rem;
    logic                       n_job_valid;
    t_job                       n_job;
    logic [IDX_W-1:0]           n_idx;
    logic [IDX_W-1:0]           n_last_idx;

    logic                       div_busy;
    logic [TIME_W-1:0]          pts;
    logic [TIME_W-1:0]          dts;
    logic [REM100_W-1:0]        ext;
    logic [BYTE_W-1:0]          sel_byte;

    logic                       out_free;
    logic                       emit;
    logic                       is_last;
    logic                       job_done;
    logic                       in_acc;
    logic                       frame_acc;
    logic                       byte_acc;
    logic                       need_hdr;
    logic [CHUNK_W-1:0]         chunk_new;
    logic [CHUNK_W-1:0]         chunk_cur;

    psp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (frame_acc),
        .i_ts    (i_timestamp_ms),
        .o_busy  (div_busy),
        .o_q100  (pts),
        .o_r100  (ext),
        .o_q300  (dts)
    );

    psp_byte_sel u_byte_sel (
        .i_job  (r_job),
        .i_idx  (r_idx),
        .i_pts  (pts),
        .i_ext  (ext),
        .i_dts  (dts),
        .o_byte (sel_byte)
    );

    // a frame job holds its first byte until the timestamp divide is done
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit      = r_job_valid && out_free && !((r_job.kind == KIND_FRAME) && div_busy);
    assign is_last   = (r_idx == r_last_idx);
    assign job_done  = emit && is_last;
    assign o_in_ready = !r_job_valid || job_done;
    assign in_acc    = i_in_valid && o_in_ready;
    assign frame_acc = in_acc && (i_mode == MODE_FRAME);
    // payload word outside a frame is dropped
    assign byte_acc  = in_acc && (i_mode == MODE_BYTE) && (r_frame_rem != '0);

    assign need_hdr  = (r_chunk_rem == '0);
    assign chunk_new = (CMP_W'(r_frame_rem) < CMP_W'(r_limit)) ? CHUNK_W'(r_frame_rem)
                                                                : r_limit;
    assign chunk_cur = need_hdr ? chunk_new : r_chunk_rem;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_limit = CHUNK_W'(1);
        end else if (i_cfg_data > LIMIT_MAX) begin
            n_limit = LIMIT_MAX;
        end else begin
            n_limit = i_cfg_data;
        end
    end

    always_comb begin
        n_frame_rem = r_frame_rem;
        n_chunk_rem = r_chunk_rem;
        n_job_valid = r_job_valid && !job_done;
        n_job       = r_job;
        n_idx       = emit ? r_idx + 1'b1 : r_idx;
        n_last_idx  = r_last_idx;
        if (frame_acc) begin
            n_frame_rem  = i_frame_length;
            n_chunk_rem  = '0;
            n_job_valid  = 1'b1;
            n_job.kind   = KIND_FRAME;
            n_job.key    = i_key_frame;
            n_job.eoc    = 1'b1;
            n_job.eof    = (i_frame_length == '0);
            n_job.pes_len = '0;
            n_job.data   = '0;
            n_idx        = '0;
            n_last_idx   = i_key_frame ? IDX_FRAME_LAST_KEY : IDX_FRAME_LAST_NOKEY;
        end else if (byte_acc) begin
            n_frame_rem  = r_frame_rem - 1'b1;
            n_chunk_rem  = chunk_cur - 1'b1;
            n_job_valid  = 1'b1;
            n_job.kind   = KIND_PES;
            n_job.key    = 1'b0;
            n_job.eoc    = (chunk_cur == CHUNK_W'(1));
            n_job.eof    = (r_frame_rem == FRAME_LEN_BITS'(1));
            n_job.pes_len = chunk_cur + PES_LEN_EXTRA;
            n_job.data   = i_payload_byte;
            n_idx        = need_hdr ? '0 : IDX_PES_DATA;
            n_last_idx   = IDX_PES_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_frame_rem <= '0;
            r_chunk_rem <= '0;
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= n_limit;
            end
            r_frame_rem <= n_frame_rem;
            r_chunk_rem <= n_chunk_rem;
            r_job_valid <= n_job_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_eoc  <= is_last && r_job.eoc;
            r_out_eof  <= is_last && r_job.eof;
            r_out_last <= is_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_chunk = r_out_eoc;
    assign o_end_of_frame = r_out_eof;
    assign o_last_of_item = r_out_last;

endmodule

`default_nettype wire

/* rtl/core/psp_checker.sv */
// ---------------------------------------------------------------------------
// psp_checker
// Port-level checks of the program stream packetizer output channel.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [psp_pkg::BYTE_W-1:0]   o_out_byte,
    input wire logic                         o_end_of_chunk,
    input wire logic                         o_end_of_frame,
    input wire logic                         o_last_of_item
);

    // a stalled word keeps its byte and its last-of-item flag
    `PSP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) && $stable(o_last_of_item)), "output word changed while stalled")

    // the last payload byte of a frame always closes its PES packet
    `PSP_ASSERT(a_eof_eoc, i_clk, i_rst_n, (o_out_valid && o_end_of_frame |-> o_end_of_chunk), "end of frame without end of chunk")

    // a packet or header group only ends on the last word of an input word
    `PSP_ASSERT(a_eoc_last, i_clk, i_rst_n, (o_out_valid && o_end_of_chunk |-> o_last_of_item), "end of chunk before last word of item")

    // output channel is empty right after reset
    `PSP_ASSERT_ALWAYS(a_rst_empty, i_clk, (!i_rst_n |=> !o_out_valid), "output valid after reset")

endmodule

bind program_stream_packetizer psp_checker u_psp_checker (.*);

`default_nettype wire
